// ===== hdl/bcg_pkg.sv =====
// ----------------------------------------------------------------------------
// Battery gauge package
// Types, register indexes and fixed constants shared by the gauge modules.
// ----------------------------------------------------------------------------
package bcg_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_CELL_MV    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CELL_MV    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BATT_CAP       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LSB_NA = 4'd3;

    localparam logic [14:0] MIN_CELL_MV_RST    = 15'd3000;
    localparam logic [14:0] MAX_CELL_MV_RST    = 15'd4200;
    localparam logic [15:0] BATT_CAP_RST       = 16'd2000;
    localparam logic [19:0] CURRENT_LSB_NA_RST = 20'd91553;

    localparam logic [2:0] STATUS_CRITICAL  = 3'd0;
    localparam logic [2:0] STATUS_LOW       = 3'd1;
    localparam logic [2:0] STATUS_FAIR      = 3'd2;
    localparam logic [2:0] STATUS_GOOD      = 3'd3;
    localparam logic [2:0] STATUS_EXCELLENT = 3'd4;

    // Quotient bits produced by the divider chain, one per cell.
    localparam int NUM_CELLS = 26;
    localparam int NA_W      = 36;

    // ceil(2^39 / 125): the magnitude divided by 8 times this, shifted right
    // by 39, is the magnitude divided by 1000 for every 32-bit input.
    localparam logic [32:0] UA_RECIP = 33'd4398046512;

    localparam logic [15:0] RUNTIME_MAX = 16'hFFFF;
    localparam logic [25:0] UA_POS_MAX  = 26'h1FFFFFF;
    localparam logic [25:0] UA_NEG_MAX  = 26'h2000000;
    localparam logic [13:0] FULL_CHARGE = 14'd10000;

    typedef struct packed {
        logic [14:0] min_cell_mv;
        logic [14:0] max_cell_mv;
        logic [15:0] batt_cap;
        logic [19:0] current_lsb_na;
    } cfg_t;

    typedef struct packed {
        logic [14:0] bus_mv;
        logic [13:0] pct;
        logic [2:0]  status;
        logic        healthy;
        logic        no_draw;
        logic        neg;
    } meta_t;

    // The runtime restoring division lane travels through the chain together
    // with the finished current magnitude in microamps.
    typedef struct packed {
        logic [NA_W-1:0]      rt_rem;
        logic [NA_W-1:0]      rt_den;
        logic [NUM_CELLS-1:0] rt_low;
        logic                 rt_ovf;
        logic [25:0]          ua_quot;
        meta_t                meta;
    } cell_t;

endpackage

// ===== hdl/bcg_ifs.sv =====
// ----------------------------------------------------------------------------
// Battery gauge channel interfaces
// Sample input, result output and register write channels.
// ----------------------------------------------------------------------------
interface bcg_sample_if;
    logic               valid;
    logic               ready;
    logic [15:0]        bus_raw;
    logic signed [15:0] current_raw;

    modport source (output valid, bus_raw, current_raw, input ready);
    modport sink   (input valid, bus_raw, current_raw, output ready);
endinterface

interface bcg_result_if;
    logic               valid;
    logic               ready;
    logic [14:0]        bus_mv;
    logic signed [25:0] current_ua;
    logic [13:0]        charge_centipct;
    logic [2:0]         charge_status;
    logic               is_healthy;
    logic [15:0]        runtime_min;
    logic               no_draw;

    modport source (output valid, bus_mv, current_ua, charge_centipct, charge_status,
                    is_healthy, runtime_min, no_draw, input ready);
    modport sink   (input valid, bus_mv, current_ua, charge_centipct, charge_status,
                    is_healthy, runtime_min, no_draw, output ready);
endinterface

interface bcg_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [19:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/bcg_prep.sv =====
// ----------------------------------------------------------------------------
// Battery gauge front end
// Converts a sample to millivolts, charge and nanoamps, divides the current
// magnitude by 1000, forms the runtime numerator and loads the runtime
// division lane for the cell chain.
// ----------------------------------------------------------------------------
module bcg_prep (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [15:0]        bus_raw,
    input  logic signed [15:0] current_raw,
    input  bcg_pkg::cfg_t      cfg,
    output logic               out_valid,
    output bcg_pkg::cell_t     out_data
);
    import bcg_pkg::*;

    function automatic logic [13:0] curve_centipct(input logic [14:0] v);
        logic [14:0] d;
        logic [13:0] p;
        begin
            d = 15'd0;
            if (v >= 15'd4100)
            begin
                p = FULL_CHARGE;
            end
            else if (v >= 15'd3900)
            begin
                d = v - 15'd3900;
                p = 14'(15'd9000 + d * 15'd5);
            end
            else if (v >= 15'd3800)
            begin
                d = v - 15'd3800;
                p = 14'(15'd7000 + d * 15'd20);
            end
            else if (v >= 15'd3700)
            begin
                d = v - 15'd3700;
                p = 14'(15'd4000 + d * 15'd30);
            end
            else if (v >= 15'd3600)
            begin
                d = v - 15'd3600;
                p = 14'(15'd2000 + d * 15'd20);
            end
            else if (v >= 15'd3400)
            begin
                d = v - 15'd3400;
                p = 14'(15'd500 + ((d * 15'd15) >> 1));
            end
            else if (v >= 15'd3000)
            begin
                d = v - 15'd3000;
                p = 14'((d * 15'd5) >> 2);
            end
            else
            begin
                p = 14'd0;
            end
            curve_centipct = p;
        end
    endfunction

    // Stage 1: voltage, charge curve, status and current in nanoamps.
    logic [14:0]            bus_mv;
    logic [13:0]            pct;
    logic [2:0]             status;
    logic signed [NA_W-1:0] na_full;
    meta_t                  s1_meta_next;

    logic                   s1_valid_reg;
    meta_t                  s1_meta_reg;
    logic signed [NA_W-1:0] s1_na_reg;

    always_comb
    begin
        bus_mv  = {bus_raw[15:3], 2'b00};
        pct     = curve_centipct(bus_mv);
        na_full = current_raw * $signed({1'b0, cfg.current_lsb_na});
        if (bus_mv < cfg.min_cell_mv)
        begin
            status = STATUS_CRITICAL;
        end
        else if (pct < 14'd1000)
        begin
            status = STATUS_LOW;
        end
        else if (pct < 14'd2500)
        begin
            status = STATUS_FAIR;
        end
        else if (pct < 14'd7500)
        begin
            status = STATUS_GOOD;
        end
        else
        begin
            status = STATUS_EXCELLENT;
        end
        s1_meta_next.bus_mv  = bus_mv;
        s1_meta_next.pct     = pct;
        s1_meta_next.status  = status;
        s1_meta_next.healthy = (bus_mv >= cfg.min_cell_mv) && (bus_mv <= cfg.max_cell_mv);
        s1_meta_next.no_draw = 1'b0;
        s1_meta_next.neg     = 1'b0;
    end

    // Stage 2: capacity times charge, current magnitude and draw flags.
    meta_t           s2_meta_next;
    logic [NA_W-1:0] s2_mag_next;

    logic            s2_valid_reg;
    meta_t           s2_meta_reg;
    logic [29:0]     s2_prod_reg;
    logic [NA_W-1:0] s2_mag_reg;
    logic [NA_W-1:0] s2_den_reg;

    always_comb
    begin
        s2_meta_next         = s1_meta_reg;
        s2_meta_next.neg     = s1_na_reg[NA_W-1];
        s2_meta_next.no_draw = s1_na_reg[NA_W-1] || (s1_na_reg == '0);
        s2_mag_next          = s1_na_reg[NA_W-1] ? NA_W'(-s1_na_reg) : NA_W'(s1_na_reg);
    end

    // Stage 3: runtime numerator, capacity * charge * 6000, and the two halves
    // of the reciprocal product for the microamp quotient. The magnitude stays
    // below 2^35, so an eighth of it fits in 32 bits after dropping three bits.
    logic [42:0]     num_full;
    logic [31:0]     mag_div8;
    logic            s3_valid_reg;
    meta_t           s3_meta_reg;
    logic [41:0]     s3_num_reg;
    logic [48:0]     s3_ua_lo_reg;
    logic [48:0]     s3_ua_hi_reg;
    logic [NA_W-1:0] s3_den_reg;

    assign num_full = s2_prod_reg * 13'd6000;
    assign mag_div8 = s2_mag_reg[34:3];

    // Stage 4: finish the microamp quotient and load the runtime lane. A
    // quotient too large for the chain is flagged here and saturates at the end.
    logic [64:0] ua_prod;
    cell_t       s4_next;
    cell_t       s4_data_reg;
    logic        s4_valid_reg;

    assign ua_prod = {s3_ua_hi_reg, 16'd0} + {16'd0, s3_ua_lo_reg};

    always_comb
    begin
        s4_next.rt_rem  = {20'd0, s3_num_reg[41:26]};
        s4_next.rt_den  = s3_den_reg;
        s4_next.rt_low  = s3_num_reg[25:0];
        s4_next.rt_ovf  = {20'd0, s3_num_reg[41:26]} >= s3_den_reg;
        s4_next.ua_quot = ua_prod[64:39];
        s4_next.meta    = s3_meta_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_meta_reg  <= s1_meta_next;
            s1_na_reg    <= na_full;
            s2_meta_reg  <= s2_meta_next;
            s2_prod_reg  <= 30'(s1_meta_reg.pct * cfg.batt_cap);
            s2_mag_reg   <= s2_mag_next;
            s2_den_reg   <= s1_na_reg;
            s3_meta_reg  <= s2_meta_reg;
            s3_num_reg   <= num_full[41:0];
            s3_ua_lo_reg <= 49'(mag_div8[15:0] * UA_RECIP);
            s3_ua_hi_reg <= 49'(mag_div8[31:16] * UA_RECIP);
            s3_den_reg   <= s2_den_reg;
            s4_data_reg  <= s4_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_data  = s4_data_reg;

endmodule

// ===== hdl/bcg_cell.sv =====
// ----------------------------------------------------------------------------
// Battery gauge divider cell
// One restoring step on the runtime lane per cell; the rest of the item
// passes through unchanged.
// ----------------------------------------------------------------------------
module bcg_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  bcg_pkg::cell_t in_data,
    output logic           out_valid,
    output bcg_pkg::cell_t out_data
);
    import bcg_pkg::*;

    logic [NA_W:0]     rt_trial;
    logic              rt_ge;
    cell_t             data_next;
    cell_t             data_reg;
    logic              valid_reg;

    always_comb
    begin
        rt_trial = {in_data.rt_rem, in_data.rt_low[NUM_CELLS-1]};
        rt_ge    = rt_trial >= {1'b0, in_data.rt_den};

        data_next        = in_data;
        data_next.rt_rem = rt_ge ? NA_W'(rt_trial - {1'b0, in_data.rt_den})
                                 : rt_trial[NA_W-1:0];
        data_next.rt_low = {in_data.rt_low[NUM_CELLS-2:0], rt_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/battery_charge_and_runtime_gauge_unit.sv =====
// ----------------------------------------------------------------------------
// Battery charge and runtime gauge
// Turns raw bus and current samples into voltage, current, charge, status,
// health and remaining runtime.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one raw monitor item (bus_raw, current_raw) per valid/ready beat.
//   result : one item per sample, in order, with all seven result fields.
//   cfg    : register writes (index 0 min_cell_mv, 1 max_cell_mv,
//            2 capacity in mAh, 3 current_lsb_na); always ready, other indexes
//            are dropped. Write only while no item is in flight.
// Pipeline:
//   An accepted item reaches result through four front-end stages
//   (microamps finished by a reciprocal multiply),
//   a chain of 26 divider cells (one runtime quotient bit each) and the
//   output register.
//   While result is not stalled, one item is accepted every cycle; throughput is one item per clock.
// Reset clears every valid flag and loads the register defaults
// (3000 mV, 4200 mV, 2000 mAh, 91553 nA per count).
// When result is stalled, the whole pipeline holds and sample.ready drops;
// it stays high whenever the output register is empty or being taken.
// ----------------------------------------------------------------------------
module battery_charge_and_runtime_gauge_unit (
    input  logic         clk,
    input  logic         rst_n,
    bcg_cfg_if.sink      cfg,
    bcg_sample_if.sink   sample,
    bcg_result_if.source result
);
    import bcg_pkg::*;

    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_cell_mv    <= MIN_CELL_MV_RST;
            cfg_reg.max_cell_mv    <= MAX_CELL_MV_RST;
            cfg_reg.batt_cap       <= BATT_CAP_RST;
            cfg_reg.current_lsb_na <= CURRENT_LSB_NA_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_MIN_CELL_MV:    cfg_reg.min_cell_mv    <= cfg.data[14:0];
                REG_MAX_CELL_MV:    cfg_reg.max_cell_mv    <= cfg.data[14:0];
                REG_BATT_CAP:       cfg_reg.batt_cap       <= cfg.data[15:0];
                REG_CURRENT_LSB_NA: cfg_reg.current_lsb_na <= cfg.data[19:0];
                default:            ;
            endcase
        end
    end

    logic adv;
    logic out_valid_reg;

    assign adv          = !out_valid_reg || result.ready;
    assign sample.ready = adv;

    logic  chain_valid [0:NUM_CELLS];
    cell_t chain_data  [0:NUM_CELLS];

    bcg_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (sample.valid),
        .bus_raw     (sample.bus_raw),
        .current_raw (sample.current_raw),
        .cfg         (cfg_reg),
        .out_valid   (chain_valid[0]),
        .out_data    (chain_data[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        bcg_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // Sign, saturation and the no-draw override on the finished quotients.
    cell_t              last;
    logic [25:0]        ua_q;
    logic signed [25:0] ua_next;
    logic [15:0]        rt_next;

    always_comb
    begin
        last = chain_data[NUM_CELLS];
        ua_q = last.ua_quot;
        if (last.meta.neg)
        begin
            ua_next = (ua_q > UA_NEG_MAX) ? $signed(UA_NEG_MAX) : $signed(26'(-ua_q));
        end
        else
        begin
            ua_next = (ua_q > UA_POS_MAX) ? $signed(UA_POS_MAX) : $signed(ua_q);
        end
        if (last.meta.no_draw || last.rt_ovf || (|last.rt_low[NUM_CELLS-1:16]))
        begin
            rt_next = RUNTIME_MAX;
        end
        else
        begin
            rt_next = last.rt_low[15:0];
        end
    end

    logic [14:0]        bus_mv_reg;
    logic signed [25:0] current_ua_reg;
    logic [13:0]        pct_reg;
    logic [2:0]         status_reg;
    logic               healthy_reg;
    logic [15:0]        runtime_reg;
    logic               no_draw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= chain_valid[NUM_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bus_mv_reg     <= last.meta.bus_mv;
            current_ua_reg <= ua_next;
            pct_reg        <= last.meta.pct;
            status_reg     <= last.meta.status;
            healthy_reg    <= last.meta.healthy;
            runtime_reg    <= rt_next;
            no_draw_reg    <= last.meta.no_draw;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.bus_mv          = bus_mv_reg;
    assign result.current_ua      = current_ua_reg;
    assign result.charge_centipct = pct_reg;
    assign result.charge_status   = status_reg;
    assign result.is_healthy      = healthy_reg;
    assign result.runtime_min     = runtime_reg;
    assign result.no_draw         = no_draw_reg;

endmodule

// ===== hdl/bcg_checker.sv =====
// ----------------------------------------------------------------------------
// Battery gauge port checker
// Watches the result channel of the gauge and checks field relations.
// ----------------------------------------------------------------------------
module bcg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        r_valid,
    input logic        r_ready,
    input logic [13:0] pct,
    input logic [2:0]  status,
    input logic        healthy,
    input logic [15:0] runtime,
    input logic        no_draw
);
    import bcg_pkg::*;

    // A stalled result must stay valid and hold its runtime and charge.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid && $stable(runtime) && $stable(pct))
        else $error("result item changed while stalled");

    // Without draw the runtime reads as its maximum.
    a_no_draw_runtime: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && no_draw |-> runtime == RUNTIME_MAX)
        else $error("no draw but runtime is not saturated");

    // A healthy cell is at or above the minimum voltage, so never critical.
    a_healthy_status: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && healthy |-> status != STATUS_CRITICAL)
        else $error("healthy cell reported as critical");

    // High charge is at most full and is either excellent or below the minimum voltage.
    a_charge_status: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && pct >= 14'd7500 |->
            pct <= FULL_CHARGE &&
            (status == STATUS_EXCELLENT || status == STATUS_CRITICAL))
        else $error("charge and status disagree");

endmodule

bind battery_charge_and_runtime_gauge_unit bcg_checker u_bcg_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .r_valid (result.valid),
    .r_ready (result.ready),
    .pct     (result.charge_centipct),
    .status  (result.charge_status),
    .healthy (result.is_healthy),
    .runtime (result.runtime_min),
    .no_draw (result.no_draw)
);
